// ===== hdl/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg - shared types for the greedy box suppression block
// Word layouts, queue entry, sequencer states and small helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package gbn_pkg;

    localparam logic [15:0] ThrReset = 16'd29491;

    typedef struct packed {
        logic [15:0] left_edge;
        logic [15:0] top_edge;
        logic [15:0] right_edge;
        logic [15:0] bottom_edge;
        logic [15:0] box_score;
        logic        final_box;
    } t_box_in;

    typedef struct packed {
        logic [5:0] kept_index;
        logic       final_kept;
    } t_kept_out;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
    } t_box;

    typedef struct packed {
        logic    store;
        t_box_in word;
    } t_q_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANK,
        S_RDA,
        S_RDB,
        S_CHK,
        S_INNER,
        S_FLUSH
    } t_state;

    function automatic logic [15:0] span16(input logic [15:0] lo, input logic [15:0] hi);
        span16 = (hi > lo) ? (hi - lo) : 16'd0;
    endfunction

    function automatic logic [15:0] max16(input logic [15:0] a, input logic [15:0] b);
        max16 = (a > b) ? a : b;
    endfunction

    function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
        min16 = (a < b) ? a : b;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/gbn_front.sv =====
// ----------------------------------------------------------------------------
// gbn_front - load side
// Accepts box words, masks coordinates and marks loads beyond the store as drops.
// ----------------------------------------------------------------------------
`default_nettype none
module gbn_front #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire gbn_pkg::t_box_in i_in_data,
    input  wire logic             i_q_full,
    output logic                  o_q_push,
    output gbn_pkg::t_q_entry     o_q_entry
);
    import gbn_pkg::*;

    localparam int CW  = $clog2(MAX_BOXES + 1);
    localparam int CmW = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam logic [15:0] CoordMask = 16'((32'd1 << CmW) - 32'd1);

    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_store;

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;
    assign w_store    = r_cnt < CW'(MAX_BOXES);

    always_comb begin
        o_q_entry                  = '0;
        o_q_entry.store            = w_store;
        o_q_entry.word.left_edge   = i_in_data.left_edge & CoordMask;
        o_q_entry.word.top_edge    = i_in_data.top_edge & CoordMask;
        o_q_entry.word.right_edge  = i_in_data.right_edge & CoordMask;
        o_q_entry.word.bottom_edge = i_in_data.bottom_edge & CoordMask;
        o_q_entry.word.box_score   = i_in_data.box_score;
        o_q_entry.word.final_box   = i_in_data.final_box;
        n_cnt = r_cnt;
        if (o_q_push) begin
            if (i_in_data.final_box) begin
                n_cnt = '0;
            end else if (w_store) begin
                n_cnt = r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/gbn_queue.sv =====
// ----------------------------------------------------------------------------
// gbn_queue - two-entry queue between load side and suppression engine
// Holds load words while the engine is busy with a set; head is registered.
// ----------------------------------------------------------------------------
`default_nettype none
module gbn_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire gbn_pkg::t_q_entry i_entry,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output logic                   o_full,
    output gbn_pkg::t_q_entry      o_head
);
    import gbn_pkg::*;

    t_q_entry   r_e0, r_e1;
    logic [1:0] r_cnt;

    assign o_valid = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;
    assign o_head  = r_e0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            if (i_push && r_cnt == 2'd1) begin
                r_e0 <= i_entry;
            end else begin
                r_e0 <= r_e1;
            end
            if (i_push && r_cnt == 2'd2) begin
                r_e1 <= i_entry;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_e0 <= i_entry;
            end else begin
                r_e1 <= i_entry;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/gbn_engine.sv =====
// ----------------------------------------------------------------------------
// gbn_engine - ranking and greedy suppression engine
// Stores a set, ranks it by score, walks it and emits the kept indices.
// ----------------------------------------------------------------------------
`default_nettype none
module gbn_engine #(
    parameter int MAX_BOXES = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [15:0]       i_cfg_wdata,
    input  wire logic              i_q_valid,
    input  wire gbn_pkg::t_q_entry i_q_head,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output gbn_pkg::t_kept_out     o_out_data
);
    import gbn_pkg::*;

    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    // storage
    t_box        box_mem   [MAX_BOXES];
    logic [15:0] score_mem [MAX_BOXES];
    logic [IW-1:0] srt_mem [MAX_BOXES];
    logic        sup_mem   [MAX_BOXES];

    t_box        r_box_q;
    logic [15:0] r_sc_j, r_sc_i;
    logic [IW-1:0] r_srt_q;
    logic        r_sup_q;

    // memory controls
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic          sc_re;
    logic [IW-1:0] sc_ra_j, sc_ra_i;
    logic          srt_we, srt_re;
    logic [IW-1:0] srt_wa, srt_wd, srt_ra;
    logic          box_re;
    logic [IW-1:0] box_ra;
    logic          sup_we, sup_wd, sup_re;
    logic [IW-1:0] sup_wa, sup_ra;

    t_state        r_st, n_st;
    logic [15:0]   r_thr;
    logic [CW-1:0] r_wcnt, n_wcnt;
    logic [IW-1:0] r_i, n_i, r_rj, n_rj, r_rank, n_rank, r_p, n_p;
    logic [CW-1:0] r_j, n_j;
    logic          r_rv, n_rv;
    logic [IW-1:0] r_a, n_a, r_pend, n_pend;
    logic          r_pend_v, n_pend_v;
    t_box          r_box_a, n_box_a;
    logic [31:0]   r_area_a, n_area_a;

    // pair pipeline
    logic          r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic [IW-1:0] r_b2, r_b3, r_b4, r_b5, r_b6;
    logic [15:0]   r_wb, r_hb, r_iw, r_ih;
    logic [31:0]   r_areab, r_int4, r_int5, r_int6;
    logic [32:0]   r_uni;
    logic [48:0]   r_prod;

    logic          r_out_v, n_out_v;
    t_kept_out     r_out_d, n_out_d;

    logic          w_out_free, w_push, w_final_push, w_pipe_busy, w_inc;
    logic [IW-1:0] w_last, w_rk;
    logic [15:0]   w_ix1, w_iy1, w_ix2, w_iy2;

    assign w_out_free  = !r_out_v || i_out_ready;
    assign w_last      = IW'(r_wcnt - CW'(1));
    assign w_pipe_busy = r_v1 || r_v2 || r_v3 || r_v4 || r_v5 || r_v6;
    assign w_inc       = (r_sc_j > r_sc_i) || (r_sc_j == r_sc_i && r_rj < r_i);
    assign w_rk        = r_rank + IW'(w_inc);
    assign w_ix1       = max16(r_box_a.left, r_box_q.left);
    assign w_iy1       = max16(r_box_a.top, r_box_q.top);
    assign w_ix2       = min16(r_box_a.right, r_box_q.right);
    assign w_iy2       = min16(r_box_a.bottom, r_box_q.bottom);
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out_d;

    always_comb begin
        n_st = r_st;   n_wcnt = r_wcnt; n_i = r_i;     n_j = r_j;
        n_rj = r_rj;   n_rv = 1'b0;     n_rank = r_rank; n_p = r_p;
        n_a = r_a;     n_pend = r_pend; n_pend_v = r_pend_v;
        n_box_a = r_box_a; n_area_a = r_area_a;
        o_q_pop = 1'b0; wr_en = 1'b0; wr_addr = IW'(r_wcnt);
        sc_re = 1'b0; sc_ra_j = r_j[IW-1:0]; sc_ra_i = r_i;
        srt_we = 1'b0; srt_wa = w_rk; srt_wd = r_i;
        srt_re = 1'b0; srt_ra = r_p;
        box_re = 1'b0; box_ra = r_srt_q;
        sup_we = 1'b0; sup_wa = r_i; sup_wd = 1'b0;
        sup_re = 1'b0; sup_ra = r_srt_q;
        w_push = 1'b0; w_final_push = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_head.store) begin
                        wr_en  = 1'b1;
                        n_wcnt = r_wcnt + CW'(1);
                    end
                    if (i_q_head.word.final_box) begin
                        n_st = S_RANK; n_i = '0; n_j = '0; n_rank = '0;
                    end
                end
            end
            S_RANK: begin
                // stream every score against the current one
                if (r_j < r_wcnt) begin
                    sc_re = 1'b1;
                    n_j   = r_j + CW'(1);
                    n_rv  = 1'b1;
                    n_rj  = r_j[IW-1:0];
                end
                if (r_rv) begin
                    n_rank = w_rk;
                    if (r_rj == w_last) begin
                        srt_we = 1'b1;
                        sup_we = 1'b1;
                        n_rank = '0;
                        n_j    = '0;
                        if (r_i == w_last) begin
                            n_st = S_RDA; n_p = '0;
                        end else begin
                            n_i = r_i + IW'(1);
                        end
                    end
                end
            end
            S_RDA: begin
                srt_re = 1'b1;
                n_st   = S_RDB;
            end
            S_RDB: begin
                n_a    = r_srt_q;
                sup_re = 1'b1;
                box_re = 1'b1;
                n_st   = S_CHK;
            end
            S_CHK: begin
                if (r_sup_q) begin
                    if (r_p == w_last) begin
                        n_st = S_FLUSH;
                    end else begin
                        n_p = r_p + IW'(1); n_st = S_RDA;
                    end
                end else if (!r_pend_v || w_out_free) begin
                    // hold the new kept box back until the next one proves it is not last
                    w_push   = r_pend_v;
                    n_pend   = r_a;
                    n_pend_v = 1'b1;
                    n_box_a  = r_box_q;
                    n_area_a = 32'(span16(r_box_q.left, r_box_q.right))
                             * 32'(span16(r_box_q.top, r_box_q.bottom));
                    n_j      = CW'(r_p) + CW'(1);
                    n_st     = S_INNER;
                end
            end
            S_INNER: begin
                if (r_j < r_wcnt) begin
                    srt_re = 1'b1;
                    srt_ra = r_j[IW-1:0];
                    n_j    = r_j + CW'(1);
                end
                if (r_v1) begin
                    box_re = 1'b1;
                end
                if (r_v6 && ({r_int6, 16'h0} > r_prod)) begin
                    sup_we = 1'b1; sup_wa = r_b6; sup_wd = 1'b1;
                end
                if (r_j >= r_wcnt && !w_pipe_busy) begin
                    if (r_p == w_last) begin
                        n_st = S_FLUSH;
                    end else begin
                        n_p = r_p + IW'(1); n_st = S_RDA;
                    end
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    w_push = 1'b1; w_final_push = 1'b1;
                    n_pend_v = 1'b0; n_wcnt = '0; n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
        n_out_d = r_out_d;
        if (w_push) begin
            n_out_v = 1'b1;
            n_out_d.kept_index = 6'(r_pend);
            n_out_d.final_kept = w_final_push;
        end else begin
            n_out_v = r_out_v && !i_out_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_thr <= ThrReset; r_wcnt <= '0; r_rv <= 1'b0;
            r_pend_v <= 1'b0; r_out_v <= 1'b0;
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_v4 <= 1'b0; r_v5 <= 1'b0; r_v6 <= 1'b0;
        end else begin
            r_st <= n_st; r_wcnt <= n_wcnt; r_rv <= n_rv;
            r_pend_v <= n_pend_v; r_out_v <= n_out_v;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            r_v1 <= srt_re && r_st == S_INNER;
            r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3; r_v5 <= r_v4; r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_j <= n_j; r_rj <= n_rj; r_rank <= n_rank; r_p <= n_p;
        r_a <= n_a; r_pend <= n_pend; r_box_a <= n_box_a; r_area_a <= n_area_a;
        r_out_d <= n_out_d;
        r_b2 <= r_srt_q;
        r_b3 <= r_b2;
        r_wb <= span16(r_box_q.left, r_box_q.right);
        r_hb <= span16(r_box_q.top, r_box_q.bottom);
        r_iw <= span16(w_ix1, w_ix2);
        r_ih <= span16(w_iy1, w_iy2);
        r_b4 <= r_b3;
        r_areab <= 32'(r_wb) * 32'(r_hb);
        r_int4 <= 32'(r_iw) * 32'(r_ih);
        r_b5 <= r_b4;
        r_uni <= 33'(r_area_a) + 33'(r_areab) - 33'(r_int4);
        r_int5 <= r_int4;
        r_b6 <= r_b5;
        r_prod <= 49'(r_uni) * 49'(r_thr);
        r_int6 <= r_int5;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            box_mem[wr_addr] <= '{left:   i_q_head.word.left_edge,
                                  top:    i_q_head.word.top_edge,
                                  right:  i_q_head.word.right_edge,
                                  bottom: i_q_head.word.bottom_edge};
            score_mem[wr_addr] <= i_q_head.word.box_score;
        end
        if (box_re) begin
            r_box_q <= box_mem[box_ra];
        end
        if (sc_re) begin
            r_sc_j <= score_mem[sc_ra_j];
            r_sc_i <= score_mem[sc_ra_i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (srt_we) begin
            srt_mem[srt_wa] <= srt_wd;
        end
        if (srt_re) begin
            r_srt_q <= srt_mem[srt_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sup_we) begin
            sup_mem[sup_wa] <= sup_wd;
        end
        if (sup_re) begin
            r_sup_q <= sup_mem[sup_ra];
        end
    end

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE) |-> !w_pipe_busy)
        else $error("pair pipeline busy while idle");

    a_store_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcnt <= CW'(MAX_BOXES))
        else $error("store count beyond depth");

    a_flush_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_FLUSH && n_st == S_IDLE) |=> (r_out_v && r_out_d.final_kept))
        else $error("set closed without a final word");

    a_walk_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_INNER) |-> r_pend_v)
        else $error("suppression pass without a kept box");

endmodule
`default_nettype wire

// ===== hdl/greedy_box_nms.sv =====
// ----------------------------------------------------------------------------
// greedy_box_nms - greedy IoU non-maximum suppression
// Loads a set of boxes, ranks them by score and emits the kept load indices.
// ----------------------------------------------------------------------------
//  channel | signals                              | moves
//  in      | i_in_valid / o_in_ready / i_in_data  | one box word per handshake
//  out     | o_out_valid / i_out_ready / o_out_data | one kept index per handshake
//  cfg     | i_cfg_we / i_cfg_wdata               | IoU threshold, Q0.16
//
//  Loading takes one word per cycle through a two-entry queue while the engine
//  is idle. After the final word a set of N boxes is ranked by comparing every
//  score against every other on the score store, then walked: each position is
//  read and checked (S_RDA, S_RDB, S_CHK), and each kept box sends the later
//  positions through the pair pipeline; a final step flushes the last index.
//  Reset is synchronous, active low; threshold returns to 29491.
//  A stalled output holds the walk; loads wait in the queue until the set is done.
// ----------------------------------------------------------------------------
`default_nettype none
module greedy_box_nms #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire gbn_pkg::t_box_in   i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output gbn_pkg::t_kept_out      o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_wdata
);
    import gbn_pkg::*;

    logic     q_push, q_pop, q_valid, q_full;
    t_q_entry q_in, q_head;

    gbn_front #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .i_q_full(q_full), .o_q_push(q_push), .o_q_entry(q_in)
    );

    gbn_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(q_push), .i_entry(q_in), .i_pop(q_pop),
        .o_valid(q_valid), .o_full(q_full), .o_head(q_head)
    );

    gbn_engine #(.MAX_BOXES(MAX_BOXES)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_q_valid(q_valid), .i_q_head(q_head), .o_q_pop(q_pop),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

endmodule
`default_nettype wire
